@@ rtl/core/pgr_pkg.sv @@
// Shared types, codes and constants of the pulse-gap packet receiver.
// Depends on nothing; pgr_chan and the top level import it.
`default_nettype none

package pgr_pkg;

    localparam int CHANNELS_DEF     = 6;
    localparam int PACKET_BYTES_DEF = 16;

    localparam int KIND_W   = 2;
    localparam int TRIG_W   = 6;
    localparam int CHAN_W   = 3;
    localparam int INDEX_W  = 4;
    localparam int MASK_W   = 6;
    localparam int LENOUT_W = 5;
    localparam int GAP_W    = 4;
    localparam int BYTE_W   = 8;
    localparam int IN_TDATA_W  = 16;
    localparam int OUT_TDATA_W = 32;

    localparam logic [KIND_W-1:0] KIND_TICK    = 2'd0;
    localparam logic [KIND_W-1:0] KIND_RELEASE = 2'd1;
    localparam logic [KIND_W-1:0] KIND_READ    = 2'd2;

    localparam logic [BYTE_W-1:0] MARKER  = 8'b1000_0000;
    localparam logic [BYTE_W-1:0] LOW_BIT = 8'b0000_0001;
    localparam logic [GAP_W-1:0]  ONE_GAP  = 4'd1;
    localparam logic [GAP_W-1:0]  SYNC_MIN = 4'd4;
    localparam logic [GAP_W-1:0]  SYNC_MAX = 4'd6;
    localparam logic [GAP_W-1:0]  GAP_SAT  = 4'd8;

    typedef struct packed {
        logic [GAP_W-1:0]  gap;
        logic [BYTE_W-1:0] shift;
        logic              ready;
        logic              store;
        logic [BYTE_W-1:0] data;
    } t_chan_upd;

endpackage

`default_nettype wire

@@ rtl/core/pgr_ram.sv @@
// Generic single-write, single-read RAM with a registered read port.
// Depends on nothing; used for the per-channel packet byte store.
`default_nettype none

module pgr_ram #(
    parameter int WIDTH  = 8,
    parameter int DEPTH  = 96,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic              i_clk,
    input  wire logic              i_wr_en,
    input  wire logic [ADDR_W-1:0] i_wr_addr,
    input  wire logic [WIDTH-1:0]  i_wr_data,
    input  wire logic              i_rd_en,
    input  wire logic [ADDR_W-1:0] i_rd_addr,
    output logic      [WIDTH-1:0]  o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            o_rd_data <= r_mem[i_rd_addr];
        end
    end

endmodule

`default_nettype wire

@@ rtl/core/pgr_chan.sv @@
// Shared per-channel symbol decoder: gap counting, bit shifting and sync handling.
// Depends on pgr_pkg; the top level runs every channel through it in turn.
`default_nettype none

module pgr_chan #(
    parameter int PACKET_BYTES = pgr_pkg::PACKET_BYTES_DEF,
    parameter int LEN_W        = $clog2(PACKET_BYTES + 1)
) (
    input  wire logic                     i_pulse,
    input  wire logic [pgr_pkg::GAP_W-1:0]  i_gap,
    input  wire logic [pgr_pkg::BYTE_W-1:0] i_shift,
    input  wire logic [LEN_W-1:0]         i_len,
    input  wire logic                     i_ready,
    output pgr_pkg::t_chan_upd            o_upd,
    output logic      [LEN_W-1:0]         o_len
);

    import pgr_pkg::*;

    always_comb begin
        o_upd.gap   = i_gap;
        o_upd.shift = i_shift;
        o_upd.ready = i_ready;
        o_upd.store = 1'b0;
        o_upd.data  = {(i_gap <= ONE_GAP), i_shift[BYTE_W-1:1]};
        o_len       = i_len;
        if (!i_pulse) begin
            if (i_gap < GAP_SAT) begin
                o_upd.gap = i_gap + GAP_W'(1);
            end else begin
                o_upd.shift = '0;
            end
        end else begin
            o_upd.gap = '0;
            if (i_gap < SYNC_MIN) begin
                if (i_shift != '0) begin
                    if ((i_shift & LOW_BIT) != '0) begin
                        if (i_len < LEN_W'(PACKET_BYTES)) begin
                            o_upd.store = 1'b1;
                            o_upd.shift = MARKER;
                            o_len       = i_len + LEN_W'(1);
                        end else begin
                            o_upd.shift = '0;
                            o_len       = '0;
                        end
                    end else begin
                        o_upd.shift = o_upd.data;
                    end
                end
            end else if (i_gap <= SYNC_MAX) begin
                if (i_shift == MARKER) begin
                    if (i_len != '0) begin
                        o_upd.ready = 1'b1;
                        o_upd.shift = '0;
                    end
                end else if (!i_ready) begin
                    o_upd.shift = MARKER;
                    o_len       = '0;
                end
            end
        end
    end

endmodule

`default_nettype wire

@@ rtl/core/pulse_gap_packet_receiver_core.sv @@
// Pulse-gap packet receiver top level: sequencer, channel state, byte store, output register.
// Depends on pgr_pkg, pgr_chan and pgr_ram.
// A tick request runs every channel in turn through the shared decoder, then lookup and output;
// release and read requests go straight to lookup and output; input ready is low meanwhile.
// The result waits in an output register; the next request is taken while it waits.
// Synchronous active-low reset clears channel state and flags; the byte store is not cleared.
`default_nettype none

module pulse_gap_packet_receiver_core #(
    parameter int CHANNELS     = pgr_pkg::CHANNELS_DEF,
    parameter int PACKET_BYTES = pgr_pkg::PACKET_BYTES_DEF
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_s_axis_tvalid,
    output logic                                   o_s_axis_tready,
    // trigger_mask [5:0], channel [8:6], byte_index [12:9], zero fill [15:13]
    input  wire logic [pgr_pkg::IN_TDATA_W-1:0]    i_s_axis_tdata,
    // kind [1:0]
    input  wire logic [pgr_pkg::KIND_W-1:0]        i_s_axis_tuser,
    output logic                                   o_m_axis_tvalid,
    input  wire logic                              i_m_axis_tready,
    // ready_mask [5:0], busy_mask [11:6], packet_length [16:12], read_byte [24:17], zero fill
    output logic      [pgr_pkg::OUT_TDATA_W-1:0]   o_m_axis_tdata
);

    import pgr_pkg::*;

    localparam int SEL_W  = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int SEL_N  = 1 << SEL_W;
    localparam int LEN_W  = $clog2(PACKET_BYTES + 1);
    localparam int DEPTH  = CHANNELS * PACKET_BYTES;
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CMP_W  = (LEN_W > INDEX_W) ? LEN_W : INDEX_W;
    localparam logic [CHAN_W:0]  CH_LIM   = (CHAN_W + 1)'(CHANNELS);
    localparam logic [SEL_W-1:0] SEL_LAST = SEL_W'(CHANNELS - 1);

    typedef enum logic [1:0] {ST_IDLE, ST_TICK, ST_LOOKUP, ST_EMIT} t_state;

    t_state                r_state;
    logic [SEL_W-1:0]      r_sel;
    logic [KIND_W-1:0]     r_kind;
    logic [TRIG_W-1:0]     r_trig;
    logic [SEL_W-1:0]      r_ch;
    logic                  r_ch_ok;
    logic [INDEX_W-1:0]    r_idx;
    logic [GAP_W-1:0]      r_gap   [CHANNELS];
    logic [BYTE_W-1:0]     r_shift [CHANNELS];
    logic [LEN_W-1:0]      r_len   [CHANNELS];
    logic [CHANNELS-1:0]   r_ready;
    logic [LEN_W-1:0]      r_len_out;
    logic                  r_rd_ok;
    logic                  r_out_valid;
    logic [OUT_TDATA_W-1:0] r_out_data;

    logic                  in_accept;
    logic [TRIG_W-1:0]     in_trig;
    logic [CHAN_W-1:0]     in_ch;
    logic [INDEX_W-1:0]    in_idx;
    logic                  in_ch_ok;
    logic [SEL_N-1:0]      trig_sel;
    logic                  pulse;
    t_chan_upd             chan_upd;
    logic [LEN_W-1:0]      chan_len;
    logic [ADDR_W-1:0]     base_addr;
    logic [ADDR_W-1:0]     wr_addr;
    logic [ADDR_W-1:0]     rd_addr;
    logic                  wr_en;
    logic                  rd_en;
    logic                  release_hit;
    logic                  eff_ready;
    logic                  rd_ok;
    logic [BYTE_W-1:0]     rd_data;
    logic [MASK_W-1:0]     ready_mask;
    logic [MASK_W-1:0]     busy_mask;
    logic [BYTE_W-1:0]     out_byte;
    logic                  emit_load;

    assign o_s_axis_tready = (r_state == ST_IDLE);
    assign in_accept       = i_s_axis_tvalid && o_s_axis_tready;
    assign in_trig         = i_s_axis_tdata[TRIG_W-1:0];
    assign in_ch           = i_s_axis_tdata[TRIG_W+CHAN_W-1:TRIG_W];
    assign in_idx          = i_s_axis_tdata[TRIG_W+CHAN_W+INDEX_W-1:TRIG_W+CHAN_W];
    assign in_ch_ok        = ({1'b0, in_ch} < CH_LIM);

    assign trig_sel = SEL_N'({{(BYTE_W - TRIG_W){1'b0}}, r_trig});
    assign pulse    = trig_sel[r_sel];

    pgr_chan #(
        .PACKET_BYTES (PACKET_BYTES),
        .LEN_W        (LEN_W)
    ) u_chan (
        .i_pulse (pulse),
        .i_gap   (r_gap[r_sel]),
        .i_shift (r_shift[r_sel]),
        .i_len   (r_len[r_sel]),
        .i_ready (r_ready[r_sel]),
        .o_upd   (chan_upd),
        .o_len   (chan_len)
    );

    assign base_addr   = ADDR_W'(r_sel) * ADDR_W'(PACKET_BYTES);
    assign wr_addr     = base_addr + ADDR_W'(r_len[r_sel]);
    assign rd_addr     = base_addr + ADDR_W'(r_idx);
    assign wr_en       = (r_state == ST_TICK) && chan_upd.store;
    assign release_hit = (r_kind == KIND_RELEASE) && r_ch_ok;
    assign eff_ready   = r_ch_ok && r_ready[r_sel] && !release_hit;
    assign rd_ok       = eff_ready && (CMP_W'(r_idx) < CMP_W'(r_len[r_sel]));
    assign rd_en       = (r_state == ST_LOOKUP) && rd_ok;
    assign emit_load   = (r_state == ST_EMIT) && (!r_out_valid || i_m_axis_tready);

    pgr_ram #(
        .WIDTH  (BYTE_W),
        .DEPTH  (DEPTH),
        .ADDR_W (ADDR_W)
    ) u_store (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (chan_upd.data),
        .i_rd_en   (rd_en),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    always_comb begin
        ready_mask = '0;
        busy_mask  = '0;
        for (int i = 0; i < MASK_W; i++) begin
            if (i < CHANNELS) begin
                ready_mask[i] = r_ready[i];
                busy_mask[i]  = (r_shift[i] != '0);
            end
        end
    end

    assign out_byte = r_rd_ok ? rd_data : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
            r_ready     <= '0;
            for (int c = 0; c < CHANNELS; c++) begin
                r_gap[c]   <= '0;
                r_shift[c] <= '0;
                r_len[c]   <= '0;
            end
        end else begin
            if (emit_load) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && i_m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                ST_IDLE: begin
                    if (in_accept) begin
                        r_kind  <= i_s_axis_tuser;
                        r_trig  <= in_trig;
                        r_idx   <= in_idx;
                        r_ch_ok <= in_ch_ok;
                        r_ch    <= in_ch_ok ? in_ch[SEL_W-1:0] : '0;
                        if (i_s_axis_tuser == KIND_TICK) begin
                            r_sel   <= '0;
                            r_state <= ST_TICK;
                        end else begin
                            r_sel   <= in_ch_ok ? in_ch[SEL_W-1:0] : '0;
                            r_state <= ST_LOOKUP;
                        end
                    end
                end
                ST_TICK: begin
                    r_gap[r_sel]   <= chan_upd.gap;
                    r_shift[r_sel] <= chan_upd.shift;
                    r_len[r_sel]   <= chan_len;
                    r_ready[r_sel] <= chan_upd.ready;
                    if (r_sel == SEL_LAST) begin
                        r_sel   <= r_ch;
                        r_state <= ST_LOOKUP;
                    end else begin
                        r_sel <= r_sel + SEL_W'(1);
                    end
                end
                ST_LOOKUP: begin
                    if (release_hit) begin
                        r_ready[r_sel] <= 1'b0;
                    end
                    r_len_out <= eff_ready ? r_len[r_sel] : '0;
                    r_rd_ok   <= rd_ok;
                    r_state   <= ST_EMIT;
                end
                ST_EMIT: begin
                    if (emit_load) begin
                        r_out_data  <= {{(OUT_TDATA_W - 2 * MASK_W - LENOUT_W - BYTE_W){1'b0}},
                                        out_byte, LENOUT_W'(r_len_out), busy_mask, ready_mask};
                        r_state     <= ST_IDLE;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out_data;

`ifndef SYNTHESIS
    a_tick_starts_at_first: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_accept && i_s_axis_tuser == KIND_TICK) |=> (r_state == ST_TICK && r_sel == '0))
        else $error("tick request did not start the channel sweep at channel zero");

    a_store_only_in_sweep: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        wr_en |-> (r_state == ST_TICK && pulse))
        else $error("byte store written outside a pulse of the channel sweep");

    a_emit_loads_output: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_EMIT && (!r_out_valid || i_m_axis_tready))
        |=> (r_out_valid && r_state == ST_IDLE))
        else $error("result not loaded into the output register");

    a_bad_channel_no_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_LOOKUP && !r_ch_ok) |=> (r_len_out == '0 && !r_rd_ok))
        else $error("out-of-range channel reported a length or byte");
`endif

endmodule

`default_nettype wire
